// ===== rtl/core/quadratic_spline_coefficients_macros.svh =====
// ----------------------------------------------------------------------------
// quadratic spline coefficients assertion macros
// shared helpers for concurrent checks on clk and rst
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_SPLINE_COEFFICIENTS_MACROS_SVH
`define QUADRATIC_SPLINE_COEFFICIENTS_MACROS_SVH

// same-cycle implication
`define QSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define QSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/qsc_pkg.sv =====
// ----------------------------------------------------------------------------
// qsc_pkg
// types, constants and saturating helpers of the spline coefficient block
// ----------------------------------------------------------------------------
`default_nettype none

package qsc_pkg;

  localparam int MAX_SEGMENTS_DEF = 1024;

  localparam logic [7:0] CFG_INIT_SLOPE = 8'd0;
  localparam logic [7:0] CFG_PERTURB    = 8'd1;

  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  localparam logic signed [47:0] COEF_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] COEF_MIN = 48'sh8000_0000_0000;

  typedef logic signed [47:0] coef_t;

  typedef struct packed {
    logic        go;
    logic        op;
    logic [63:0] opa;
    logic [32:0] opb;
  } alu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

  function automatic coef_t sat_mag(input logic neg, input logic [80:0] m);
    coef_t r;
    if (|m[80:47]) begin
      r = neg ? COEF_MIN : COEF_MAX;
    end else begin
      r = neg ? -$signed(m[47:0]) : $signed(m[47:0]);
    end
    return r;
  endfunction

  function automatic coef_t sat_add(input coef_t a, input coef_t b);
    logic signed [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) begin
      return s[48] ? COEF_MIN : COEF_MAX;
    end
    return s[47:0];
  endfunction

  function automatic coef_t sat_sub(input coef_t a, input coef_t b);
    logic signed [48:0] s;
    s = {a[47], a} - {b[47], b};
    if (s[48] != s[47]) begin
      return s[48] ? COEF_MIN : COEF_MAX;
    end
    return s[47:0];
  endfunction

  function automatic logic [47:0] mag48(input logic [47:0] v);
    return v[47] ? 48'(-v) : v;
  endfunction

  function automatic logic [32:0] mag33(input logic [32:0] v);
    return v[32] ? 33'(-v) : v;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/qsc_alu.sv =====
// ----------------------------------------------------------------------------
// qsc_alu
// shared unsigned shift-add multiplier and restoring divider, one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module qsc_alu (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire qsc_pkg::alu_cmd_t cmd,
  output qsc_pkg::alu_sts_t     sts,
  output logic [80:0]           result
);

  localparam logic [6:0] MUL_LAST = 7'd32;
  localparam logic [6:0] DIV_LAST = 7'd63;

  logic        busy;
  logic        done;
  logic        op;
  logic [6:0]  count;
  logic [63:0] opa;
  logic [32:0] opb;
  logic [96:0] work;

  logic [64:0] mul_sum;
  logic [33:0] div_in;
  logic [34:0] div_diff;
  logic [96:0] work_next;
  logic        step_last;

  always_comb begin
    mul_sum   = {1'b0, work[96:33]} + (work[0] ? {1'b0, opa} : 65'd0);
    div_in    = {work[96:64], work[63]};
    div_diff  = {1'b0, div_in} - {2'b0, opb};
    step_last = busy && (count == ((op == qsc_pkg::OP_MUL) ? MUL_LAST : DIV_LAST));
    if (op == qsc_pkg::OP_MUL) begin
      work_next = {mul_sum, work[32:1]};
    end else if (!div_diff[34]) begin
      work_next = {div_diff[32:0], work[62:0], 1'b1};
    end else begin
      work_next = {div_in[32:0], work[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= !cmd.go && step_last;
      if (cmd.go) begin
        busy  <= 1'b1;
        count <= '0;
        op    <= cmd.op;
        opa   <= cmd.opa;
        opb   <= cmd.opb;
        work  <= (cmd.op == qsc_pkg::OP_MUL) ? {64'd0, cmd.opb} : {33'd0, cmd.opa};
      end else if (busy) begin
        work  <= work_next;
        count <= count + 7'd1;
        if (step_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign result   = (op == qsc_pkg::OP_MUL) ? work[80:0] : {17'd0, work[63:0]};

endmodule

`default_nettype wire

// ===== rtl/core/quadratic_spline_coefficients.sv =====
// a knot inside a run shows its segment after two divides and three multiplies
// on the shared unit, plus the prep, sum and emit states, and the next knot can
// be taken as the segment appears; a zero-width knot skips the unit, a first
// knot runs only the slope multiply, an ignored knot goes back to idle from prep
// throughput: one knot at a time, a stalled segment output holds the sequencer
// reset: synchronous, clears the sequencer, run state and slope registers
// ----------------------------------------------------------------------------
// quadratic_spline_coefficients
// per-segment quadratic spline coefficients from a stream of fixed-point knots
// ----------------------------------------------------------------------------
`default_nettype none

`include "quadratic_spline_coefficients_macros.svh"

module quadratic_spline_coefficients #(
  parameter int MAX_SEGMENTS = qsc_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] knot_x,
  input  wire logic signed [31:0] knot_y,
  input  wire logic               first_knot,
  input  wire logic               last_knot,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [47:0]      coef_quad,
  output logic signed [47:0]      coef_lin,
  output logic signed [47:0]      coef_const,
  output logic [9:0]              segment_index,
  output logic                    last_segment,
  output logic                    zero_width
);

  localparam int CW = (MAX_SEGMENTS > 2) ? $clog2(MAX_SEGMENTS) : 1;

  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_PREP       = 4'd1;
  localparam logic [3:0] ST_SLOPE_GO   = 4'd2;
  localparam logic [3:0] ST_SLOPE_WAIT = 4'd3;
  localparam logic [3:0] ST_R_GO       = 4'd4;
  localparam logic [3:0] ST_R_WAIT     = 4'd5;
  localparam logic [3:0] ST_A_GO       = 4'd6;
  localparam logic [3:0] ST_A_WAIT     = 4'd7;
  localparam logic [3:0] ST_B_GO       = 4'd8;
  localparam logic [3:0] ST_B_WAIT     = 4'd9;
  localparam logic [3:0] ST_T          = 4'd10;
  localparam logic [3:0] ST_C_GO       = 4'd11;
  localparam logic [3:0] ST_C_WAIT     = 4'd12;
  localparam logic [3:0] ST_S_GO       = 4'd13;
  localparam logic [3:0] ST_S_WAIT     = 4'd14;
  localparam logic [3:0] ST_EMIT       = 4'd15;

  logic [3:0]          state;
  logic [31:0]         init_slope;
  logic [31:0]         slope_perturbation;
  logic signed [31:0]  prev_x;
  logic signed [31:0]  prev_y;
  qsc_pkg::coef_t      slope;
  logic [CW-1:0]       seg_count;
  logic                run_active;

  logic signed [31:0]  x_in;
  logic signed [31:0]  y_in;
  logic                first_in;
  logic                last_in;
  logic [32:0]         dx;
  logic [32:0]         dy;
  logic                zw;
  logic                neg;
  qsc_pkg::coef_t      q;
  qsc_pkg::coef_t      a;
  qsc_pkg::coef_t      b;
  qsc_pkg::coef_t      m2;
  qsc_pkg::coef_t      t;
  qsc_pkg::coef_t      c;

  qsc_pkg::alu_cmd_t   alu_cmd;
  qsc_pkg::alu_sts_t   alu_sts;
  logic [80:0]         res;
  logic                cmd_neg;
  logic                lastseg;
  logic                emit_go;
  logic                unit_wait;

  qsc_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .cmd    (alu_cmd),
    .sts    (alu_sts),
    .result (res)
  );

  assign cfg_ready = (state == ST_IDLE);
  assign in_ready  = (state == ST_IDLE);
  assign lastseg   = last_in || (seg_count == CW'(MAX_SEGMENTS - 1));
  assign emit_go   = (state == ST_EMIT) && (!out_valid || out_ready);
  assign unit_wait = (state == ST_SLOPE_WAIT) || (state == ST_R_WAIT) ||
                     (state == ST_A_WAIT) || (state == ST_B_WAIT) ||
                     (state == ST_C_WAIT) || (state == ST_S_WAIT);

  always_comb begin
    alu_cmd = '0;
    cmd_neg = 1'b0;
    unique case (state)
      ST_SLOPE_GO: begin
        alu_cmd.go  = 1'b1;
        alu_cmd.op  = qsc_pkg::OP_MUL;
        alu_cmd.opa = {32'd0, qsc_pkg::mag32(init_slope)};
        alu_cmd.opb = {1'b0, qsc_pkg::mag32(slope_perturbation)};
        cmd_neg     = init_slope[31] ^ slope_perturbation[31];
      end
      ST_R_GO: begin
        alu_cmd.go  = 1'b1;
        alu_cmd.op  = qsc_pkg::OP_DIV;
        alu_cmd.opa = {7'd0, qsc_pkg::mag33(dy), 24'd0};
        alu_cmd.opb = qsc_pkg::mag33(dx);
        cmd_neg     = dy[32] ^ dx[32];
      end
      ST_A_GO: begin
        alu_cmd.go  = 1'b1;
        alu_cmd.op  = qsc_pkg::OP_DIV;
        alu_cmd.opa = {qsc_pkg::mag48(q), 16'd0};
        alu_cmd.opb = qsc_pkg::mag33(dx);
        cmd_neg     = q[47] ^ dx[32];
      end
      ST_B_GO: begin
        alu_cmd.go  = 1'b1;
        alu_cmd.op  = qsc_pkg::OP_MUL;
        alu_cmd.opa = {16'd0, qsc_pkg::mag48(a)};
        alu_cmd.opb = {1'b0, qsc_pkg::mag32(prev_x)};
        cmd_neg     = a[47] ^ prev_x[31];
      end
      ST_C_GO: begin
        alu_cmd.go  = 1'b1;
        alu_cmd.op  = qsc_pkg::OP_MUL;
        alu_cmd.opa = {16'd0, qsc_pkg::mag48(t)};
        alu_cmd.opb = {1'b0, qsc_pkg::mag32(prev_x)};
        cmd_neg     = t[47] ^ prev_x[31];
      end
      ST_S_GO: begin
        alu_cmd.go  = 1'b1;
        alu_cmd.op  = qsc_pkg::OP_MUL;
        alu_cmd.opa = {16'd0, qsc_pkg::mag48(a)};
        alu_cmd.opb = {1'b0, qsc_pkg::mag32(x_in)};
        cmd_neg     = a[47] ^ x_in[31];
      end
      default: begin
        alu_cmd = '0;
        cmd_neg = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      init_slope         <= '0;
      slope_perturbation <= '0;
      prev_x             <= '0;
      prev_y             <= '0;
      slope              <= '0;
      seg_count          <= '0;
      run_active         <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == qsc_pkg::CFG_INIT_SLOPE) begin
          init_slope <= cfg_data;
        end else if (cfg_index == qsc_pkg::CFG_PERTURB) begin
          slope_perturbation <= cfg_data;
        end
      end
      if (out_valid && out_ready && !emit_go) begin
        out_valid <= 1'b0;
      end
      if (alu_cmd.go) begin
        neg <= cmd_neg;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            x_in     <= knot_x;
            y_in     <= knot_y;
            first_in <= first_knot;
            last_in  <= last_knot;
            state    <= ST_PREP;
          end
        end
        ST_PREP: begin
          dx <= {x_in[31], x_in} - {prev_x[31], prev_x};
          dy <= {y_in[31], y_in} - {prev_y[31], prev_y};
          zw <= (x_in == prev_x);
          if (first_in) begin
            prev_x     <= x_in;
            prev_y     <= y_in;
            seg_count  <= '0;
            run_active <= !last_in;
            state      <= ST_SLOPE_GO;
          end else if (!run_active) begin
            state <= ST_IDLE;
          end else if (x_in == prev_x) begin
            a     <= '0;
            b     <= '0;
            c     <= '0;
            state <= ST_EMIT;
          end else begin
            state <= ST_R_GO;
          end
        end
        ST_SLOPE_GO: state <= ST_SLOPE_WAIT;
        ST_SLOPE_WAIT: begin
          if (alu_sts.done) begin
            slope <= qsc_pkg::sat_add({{8{init_slope[31]}}, init_slope, 8'd0},
                                      qsc_pkg::sat_mag(neg, res >> 8));
            state <= ST_IDLE;
          end
        end
        ST_R_GO: state <= ST_R_WAIT;
        ST_R_WAIT: begin
          if (alu_sts.done) begin
            q     <= qsc_pkg::sat_sub(qsc_pkg::sat_mag(neg, res), slope);
            state <= ST_A_GO;
          end
        end
        ST_A_GO: state <= ST_A_WAIT;
        ST_A_WAIT: begin
          if (alu_sts.done) begin
            a     <= qsc_pkg::sat_mag(neg, res);
            state <= ST_B_GO;
          end
        end
        ST_B_GO: state <= ST_B_WAIT;
        ST_B_WAIT: begin
          if (alu_sts.done) begin
            b     <= qsc_pkg::sat_sub(slope, qsc_pkg::sat_mag(neg, res >> 15));
            m2    <= qsc_pkg::sat_mag(neg, res >> 16);
            state <= ST_T;
          end
        end
        ST_T: begin
          t     <= qsc_pkg::sat_add(b, m2);
          state <= ST_C_GO;
        end
        ST_C_GO: state <= ST_C_WAIT;
        ST_C_WAIT: begin
          if (alu_sts.done) begin
            c     <= qsc_pkg::sat_sub({{8{prev_y[31]}}, prev_y, 8'd0},
                                      qsc_pkg::sat_mag(neg, res >> 16));
            state <= ST_S_GO;
          end
        end
        ST_S_GO: state <= ST_S_WAIT;
        ST_S_WAIT: begin
          if (alu_sts.done) begin
            slope <= qsc_pkg::sat_add(qsc_pkg::sat_mag(neg, res >> 15), b);
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_valid     <= 1'b1;
            coef_quad     <= a;
            coef_lin      <= b;
            coef_const    <= c;
            segment_index <= 10'(seg_count);
            last_segment  <= lastseg;
            zero_width    <= zw;
            prev_x        <= x_in;
            prev_y        <= y_in;
            seg_count     <= lastseg ? '0 : seg_count + 1'b1;
            if (lastseg) begin
              run_active <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `QSC_ASSERT_NOW(a_idle_unit_quiet, state == ST_IDLE, !alu_sts.busy, "unit busy while idle")
  `QSC_ASSERT_NOW(a_done_in_wait, alu_sts.done, unit_wait, "unit result outside a wait state")
  `QSC_ASSERT_NEXT(a_emit_sets_valid, emit_go, out_valid && state == ST_IDLE, "segment transfer not presented")

endmodule

`default_nettype wire
